@@ design/crlf_pkg.sv @@
`timescale 1ns / 1ps

package crlf_pkg;

  localparam int LINE_CAPACITY = 64;
  localparam int ADDR_W        = $clog2(LINE_CAPACITY);
  localparam int LEN_W         = 7;
  localparam int CNT_W         = 32;
  localparam int LIMIT_W       = 9;
  localparam int QUEUE_DEPTH   = 4;
  localparam int QPTR_W        = $clog2(QUEUE_DEPTH);

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 9'd64;
  localparam logic [7:0]         CHAR_CR     = 8'h0D;
  localparam logic [7:0]         CHAR_LF     = 8'h0A;

  typedef enum logic [1:0] {
    KIND_BYTE     = 2'd0,
    KIND_OVERLONG = 2'd1,
    KIND_OUTDROP  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    OP_WRITE,
    OP_LINE,
    OP_OVERLONG,
    OP_OUTDROP
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [7:0]       data;
    logic [LEN_W-1:0] len;
    logic [CNT_W-1:0] lines;
    logic [CNT_W-1:0] overlong;
    logic [CNT_W-1:0] outdrop;
  } cmd_t;

  typedef struct packed {
    logic valid;
    logic full;
  } qstat_t;

endpackage

@@ design/crlf_front.sv @@
`timescale 1ns / 1ps

module crlf_front import crlf_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         rx_byte,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [LIMIT_W-1:0] cfg_data,
  input  qstat_t             qstat,
  output logic               push,
  output cmd_t               push_cmd
);

  logic [LIMIT_W-1:0] output_limit;
  logic [LEN_W-1:0]   fill;
  logic [LEN_W-1:0]   fill_next;
  logic               overflowing;
  logic               overflowing_next;
  logic [CNT_W-1:0]   lines;
  logic [CNT_W-1:0]   lines_next;
  logic [CNT_W-1:0]   overlong;
  logic [CNT_W-1:0]   overlong_next;
  logic [CNT_W-1:0]   outdrop;
  logic [CNT_W-1:0]   outdrop_next;
  logic               accept;
  logic               is_term;

  assign in_stall  = qstat.full;
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !in_stall;
  assign is_term   = (rx_byte == CHAR_CR) || (rx_byte == CHAR_LF);

  always_comb begin
    fill_next        = fill;
    overflowing_next = overflowing;
    lines_next       = lines;
    overlong_next    = overlong;
    outdrop_next     = outdrop;
    push             = 1'b0;
    push_cmd.op      = OP_WRITE;
    push_cmd.data    = rx_byte;
    push_cmd.len     = fill;
    if (is_term) begin
      if (overflowing) begin
        overlong_next    = overlong + CNT_W'(1);
        overflowing_next = 1'b0;
        fill_next        = '0;
        push             = accept;
        push_cmd.op      = OP_OVERLONG;
      end else if (fill != '0) begin
        fill_next = '0;
        push      = accept;
        if ({{(LIMIT_W-LEN_W){1'b0}}, fill} >= output_limit) begin
          outdrop_next = outdrop + CNT_W'(1);
          push_cmd.op  = OP_OUTDROP;
        end else begin
          lines_next  = lines + CNT_W'(1);
          push_cmd.op = OP_LINE;
        end
      end
    end else if (!overflowing) begin
      if ((fill + LEN_W'(1)) >= LEN_W'(LINE_CAPACITY)) begin
        overflowing_next = 1'b1;
      end else begin
        fill_next = fill + LEN_W'(1);
        push      = accept;
      end
    end
    push_cmd.lines    = lines_next;
    push_cmd.overlong = overlong_next;
    push_cmd.outdrop  = outdrop_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      output_limit <= LIMIT_RESET;
      fill         <= '0;
      overflowing  <= 1'b0;
      lines        <= '0;
      overlong     <= '0;
      outdrop      <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        output_limit <= cfg_data;
      end
      if (accept) begin
        fill        <= fill_next;
        overflowing <= overflowing_next;
        lines       <= lines_next;
        overlong    <= overlong_next;
        outdrop     <= outdrop_next;
      end
    end
  end

endmodule

@@ design/crlf_queue.sv @@
`timescale 1ns / 1ps

module crlf_queue import crlf_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  cmd_t   push_cmd,
  input  logic   pop,
  output qstat_t qstat,
  output cmd_t   head
);

  cmd_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              do_push;
  logic              do_pop;

  assign qstat.valid = (count != '0);
  assign qstat.full  = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign head        = slots[rd_ptr];
  assign do_push     = push && !qstat.full;
  assign do_pop      = pop && qstat.valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + (QPTR_W+1)'(1);
        2'b01:   count <= count - (QPTR_W+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

@@ design/crlf_back.sv @@
`timescale 1ns / 1ps

module crlf_back import crlf_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  qstat_t           qstat,
  input  cmd_t             head,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [1:0]       kind,
  output logic [7:0]       line_byte,
  output logic             last_of_line,
  output logic [LEN_W-1:0] line_length,
  output logic [CNT_W-1:0] lines_total,
  output logic [CNT_W-1:0] overlong_total,
  output logic [CNT_W-1:0] output_drop_total
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_LOAD
  } state_t;

  state_t           state;
  logic [7:0]       line_store [LINE_CAPACITY];
  logic [7:0]       rd_data;
  logic [LEN_W-1:0] idx;
  logic [LEN_W-1:0] cur_len;
  logic [CNT_W-1:0] cur_lines;
  logic [CNT_W-1:0] cur_overlong;
  logic [CNT_W-1:0] cur_outdrop;
  logic             out_free;
  logic             store_we;
  logic             is_last;
  logic             load_out;

  assign out_free = !out_valid || !out_stall;
  assign store_we = (state == S_IDLE) && qstat.valid && (head.op == OP_WRITE);
  assign is_last  = ((idx + LEN_W'(1)) == cur_len);
  assign load_out = out_free &&
                    (((state == S_IDLE) && qstat.valid &&
                      ((head.op == OP_OVERLONG) || (head.op == OP_OUTDROP))) ||
                     (state == S_LOAD));

  always_comb begin
    pop = 1'b0;
    if ((state == S_IDLE) && qstat.valid) begin
      unique case (head.op)
        OP_WRITE, OP_LINE:       pop = 1'b1;
        OP_OVERLONG, OP_OUTDROP: pop = out_free;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (store_we) begin
      line_store[head.len[ADDR_W-1:0]] <= head.data;
    end
    if (state == S_READ) begin
      rd_data <= line_store[idx[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      out_valid <= load_out || (out_valid && out_stall);
      unique case (state)
        S_IDLE: begin
          if (qstat.valid) begin
            unique case (head.op)
              OP_WRITE: begin
              end
              OP_LINE: begin
                cur_len      <= head.len;
                cur_lines    <= head.lines;
                cur_overlong <= head.overlong;
                cur_outdrop  <= head.outdrop;
                idx          <= '0;
                state        <= S_READ;
              end
              OP_OVERLONG, OP_OUTDROP: begin
                if (out_free) begin
                  kind              <= (head.op == OP_OVERLONG) ? KIND_OVERLONG : KIND_OUTDROP;
                  line_byte         <= '0;
                  last_of_line      <= 1'b0;
                  line_length       <= head.len;
                  lines_total       <= head.lines;
                  overlong_total    <= head.overlong;
                  output_drop_total <= head.outdrop;
                end
              end
            endcase
          end
        end
        S_READ: begin
          state <= S_LOAD;
        end
        S_LOAD: begin
          if (out_free) begin
            kind              <= KIND_BYTE;
            line_byte         <= rd_data;
            last_of_line      <= is_last;
            line_length       <= cur_len;
            lines_total       <= cur_lines;
            overlong_total    <= cur_overlong;
            output_drop_total <= cur_outdrop;
            idx               <= idx + LEN_W'(1);
            state             <= is_last ? S_IDLE : S_READ;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_drop_fields: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (kind != KIND_BYTE)) |-> (!last_of_line && (line_byte == 8'd0)))
    else $error("dropped line result carries byte data");

  a_walk_in_range: assert property (@(posedge clk) disable iff (rst)
    ((state == S_READ) || (state == S_LOAD)) |-> (idx < cur_len))
    else $error("line walk ran past line length");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> qstat.valid)
    else $error("queue popped while empty");

  a_last_closes: assert property (@(posedge clk) disable iff (rst)
    ((state == S_LOAD) && out_free && is_last) |=> (state == S_IDLE))
    else $error("line walk did not end on last byte");

endmodule

@@ design/crlf_line_framer_core.sv @@
`timescale 1ns / 1ps

// Line framer for a byte stream. Bytes enter on the input channel at up to one
// per cycle and are classified at once; CR or LF ends a line. Each stored byte
// and each end of a non-empty or overlong line becomes an entry in a four-entry
// command queue, and the input stalls only while that queue is full. The back
// end writes each stored byte into the 64-byte line store, and a delivered line is
// read out of its single read port, each byte read in S_READ and then loaded
// into the output register in S_LOAD; no new command is taken until the last
// byte is loaded. Dropped lines give a single result. An output register holds
// each result until it is taken. No clearing pass is needed after reset.
module crlf_line_framer_core import crlf_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         rx_byte,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [LIMIT_W-1:0] cfg_data,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         kind,
  output logic [7:0]         line_byte,
  output logic               last_of_line,
  output logic [LEN_W-1:0]   line_length,
  output logic [CNT_W-1:0]   lines_total,
  output logic [CNT_W-1:0]   overlong_total,
  output logic [CNT_W-1:0]   output_drop_total
);

  qstat_t qstat;
  logic   push;
  cmd_t   push_cmd;
  logic   pop;
  cmd_t   head;

  crlf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .rx_byte   (rx_byte),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .qstat     (qstat),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  crlf_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .qstat    (qstat),
    .head     (head)
  );

  crlf_back u_back (
    .clk               (clk),
    .rst               (rst),
    .qstat             (qstat),
    .head              (head),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .kind              (kind),
    .line_byte         (line_byte),
    .last_of_line      (last_of_line),
    .line_length       (line_length),
    .lines_total       (lines_total),
    .overlong_total    (overlong_total),
    .output_drop_total (output_drop_total)
  );

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import crlf_pkg::*;

  localparam int CYCLE_LIMIT   = 2_000_000;
  localparam int SETTLE_CYCLES = 2 * LINE_CAPACITY + 24;
  localparam int PHASE_ITEMS   = 75;

  typedef struct {
    kind_t            kind;
    logic [7:0]       line_byte;
    logic             last_of_line;
    logic [LEN_W-1:0] line_length;
    logic [CNT_W-1:0] lines_total;
    logic [CNT_W-1:0] overlong_total;
    logic [CNT_W-1:0] output_drop_total;
  } framer_result_t;

  class line_scoreboard;
    logic [7:0]         line_mem [LINE_CAPACITY];
    int unsigned        fill;
    bit                 overflowing;
    logic [CNT_W-1:0]   lines_cnt;
    logic [CNT_W-1:0]   overlong_cnt;
    logic [CNT_W-1:0]   drop_cnt;
    logic [LIMIT_W-1:0] limit;
    framer_result_t     pending [$];
    int                 errors;

    function new();
      fill         = 0;
      overflowing  = 0;
      lines_cnt    = '0;
      overlong_cnt = '0;
      drop_cnt     = '0;
      limit        = LIMIT_RESET;
      errors       = 0;
    endfunction

    function void set_limit(logic [LIMIT_W-1:0] value);
      limit = value;
    endfunction

    function int unsigned waiting();
      return pending.size();
    endfunction

    function void push_result(kind_t k, logic [7:0] b, logic last, int unsigned len);
      framer_result_t r;
      r.kind              = k;
      r.line_byte         = b;
      r.last_of_line      = last;
      r.line_length       = len[LEN_W-1:0];
      r.lines_total       = lines_cnt;
      r.overlong_total    = overlong_cnt;
      r.output_drop_total = drop_cnt;
      pending.push_back(r);
    endfunction

    function void note_byte(logic [7:0] c);
      int unsigned len;
      len = fill;
      if (c == CHAR_CR || c == CHAR_LF) begin
        if (overflowing) begin
          overlong_cnt = overlong_cnt + 1;
          overflowing  = 0;
          fill         = 0;
          push_result(KIND_OVERLONG, 8'h00, 1'b0, len);
        end else if (len != 0) begin
          fill = 0;
          if (len >= limit) begin
            drop_cnt = drop_cnt + 1;
            push_result(KIND_OUTDROP, 8'h00, 1'b0, len);
          end else begin
            lines_cnt = lines_cnt + 1;
            for (int unsigned i = 0; i < len; i++)
              push_result(KIND_BYTE, line_mem[i], (i + 1 == len), len);
          end
        end
      end else if (!overflowing) begin
        if (len + 1 >= LINE_CAPACITY) begin
          overflowing = 1;
        end else begin
          line_mem[len] = c;
          fill = len + 1;
        end
      end
    endfunction

    function void flag(string field, logic [31:0] want, logic [31:0] seen);
      $error("%s mismatch: expected %0d, got %0d", field, want, seen);
      errors++;
    endfunction

    function void check_result(framer_result_t got);
      framer_result_t want;
      if (pending.size() == 0) begin
        $error("result with nothing expected: kind %0d byte %0d", got.kind, got.line_byte);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.kind !== want.kind) flag("kind", want.kind, got.kind);
      if (got.line_byte !== want.line_byte) flag("line_byte", want.line_byte, got.line_byte);
      if (got.last_of_line !== want.last_of_line)
        flag("last_of_line", want.last_of_line, got.last_of_line);
      if (got.line_length !== want.line_length)
        flag("line_length", want.line_length, got.line_length);
      if (got.lines_total !== want.lines_total)
        flag("lines_total", want.lines_total, got.lines_total);
      if (got.overlong_total !== want.overlong_total)
        flag("overlong_total", want.overlong_total, got.overlong_total);
      if (got.output_drop_total !== want.output_drop_total)
        flag("output_drop_total", want.output_drop_total, got.output_drop_total);
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [7:0]         rx_byte = 8'h00;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [LIMIT_W-1:0] cfg_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [1:0]         kind;
  logic [7:0]         line_byte;
  logic               last_of_line;
  logic [LEN_W-1:0]   line_length;
  logic [CNT_W-1:0]   lines_total;
  logic [CNT_W-1:0]   overlong_total;
  logic [CNT_W-1:0]   output_drop_total;

  line_scoreboard sb = new();
  bit sender_busy   = 1'b1;
  bit receiver_busy = 1'b1;
  int cycle_count   = 0;

  crlf_line_framer_core uut (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .rx_byte           (rx_byte),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_data          (cfg_data),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .kind              (kind),
    .line_byte         (line_byte),
    .last_of_line      (last_of_line),
    .line_length       (line_length),
    .lines_total       (lines_total),
    .overlong_total    (overlong_total),
    .output_drop_total (output_drop_total)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** crlf_line_framer_core: FAILED **");
      $finish;
    end
  end

  // sender: called and returns at a falling edge
  task automatic send_item(input logic [7:0] b);
    int gap;
    if ($urandom_range(0, 23) == 0) sender_busy = !sender_busy;
    gap = sender_busy ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (in_stall);
    sb.note_byte(b);
    @(negedge clk);
  endtask

  task automatic write_limit(input logic [LIMIT_W-1:0] value);
    in_valid  <= 1'b0;
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    sb.set_limit(value);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (sb.waiting() != 0);
  endtask

  task automatic settle();
    drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic logic [7:0] text_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    while (b == CHAR_CR || b == CHAR_LF) b = 8'($urandom_range(0, 255));
    return b;
  endfunction

  task automatic stream_lines(input int n_items);
    int sent;
    int len;
    int pick;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        send_item(8'($urandom_range(0, 255)));
        sent++;
      end else begin
        if (pick < 58) len = $urandom_range(1, 12);
        else if (pick < 74) len = $urandom_range(13, 45);
        else if (pick < 86) len = $urandom_range(LINE_CAPACITY - 6, LINE_CAPACITY + 4);
        else if (pick < 90) len = $urandom_range(LINE_CAPACITY + 5, 2 * LINE_CAPACITY);
        else len = 0;
        if (len > n_items - sent - 1) len = n_items - sent - 1;
        repeat (len) send_item(text_byte());
        send_item($urandom_range(0, 1) ? CHAR_CR : CHAR_LF);
        sent += len + 1;
        if ($urandom_range(0, 3) == 0) begin
          send_item(CHAR_LF);
          sent++;
        end
      end
    end
  endtask

  // result side
  initial begin
    int gap;
    framer_result_t got;
    wait (rst == 1'b0);
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 23) == 0) receiver_busy = !receiver_busy;
      gap = receiver_busy ? $urandom_range(0, 19) : 0;
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      got.kind              = kind_t'(kind);
      got.line_byte         = line_byte;
      got.last_of_line      = last_of_line;
      got.line_length       = line_length;
      got.lines_total       = lines_total;
      got.overlong_total    = overlong_total;
      got.output_drop_total = output_drop_total;
      sb.check_result(got);
      @(negedge clk);
    end
  end

  initial begin
    logic [LIMIT_W-1:0] limits [6];
    limits = '{9'd256, 9'd63, 9'd64, 9'd1, 9'd511, 9'd0};
    limits[5] = LIMIT_W'($urandom_range(1, 256));
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset limit: extremes of the byte, empty lines, cr lf pair
    send_item(8'h00);
    send_item(8'hFF);
    send_item(CHAR_CR);
    send_item(CHAR_LF);
    send_item(8'h41);
    send_item(CHAR_LF);
    send_item(CHAR_CR);

    // zero limit drops every line
    settle();
    write_limit(9'd0);
    send_item(8'h55);
    send_item(CHAR_CR);

    // limit of two: one byte passes, two bytes dropped
    settle();
    write_limit(9'd2);
    send_item(8'h01);
    send_item(CHAR_LF);
    send_item(8'h01);
    send_item(8'h02);
    send_item(CHAR_CR);
    send_item(8'h80);
    send_item(CHAR_LF);

    for (int p = 0; p < 6; p++) begin
      settle();
      write_limit(limits[p]);
      if (p == 2) begin
        stream_lines(PHASE_ITEMS / 2);
        drain();
        stream_lines(PHASE_ITEMS - PHASE_ITEMS / 2);
      end else begin
        stream_lines(PHASE_ITEMS);
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (sb.errors == 0) begin
      $display("** crlf_line_framer_core: PASSED **");
    end else begin
      $display("** crlf_line_framer_core: FAILED **");
    end
    $finish;
  end

endmodule
